### hdl/omfp_pkg.sv
package omfp_pkg;

	// one byte of a FIXUPP record body
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_in_record;
		logic       wide_displacement;
	} in_item_t;

	// one completed fixup, or an error marker
	typedef struct packed {
		logic        result_kind;
		logic        seg_rel;
		logic [3:0]  location_type;
		logic [9:0]  data_offset;
		logic [2:0]  frame_meth;
		logic [14:0] frame_idx;
		logic [1:0]  tgt_meth;
		logic [14:0] tgt_idx;
		logic [31:0] tgt_disp;
	} out_item_t;

	localparam logic KIND_FIXUP = 1'b0;
	localparam logic KIND_ERROR = 1'b1;

	// frame methods up to this one carry a datum index
	localparam logic [2:0] METHOD_LAST_INDEXED = 3'd2;
	// frame method replaced by the previous data record's segment
	localparam logic [2:0] METHOD_FRAME_LEDATA = 3'd4;
	localparam logic [2:0] METHOD_FRAME_SEGDEF = 3'd0;

	localparam logic [2:0] DISP_BYTES_WORD  = 3'd2;
	localparam logic [2:0] DISP_BYTES_DWORD = 3'd4;

endpackage

### hdl/omf_fixup_subrecord_parser.sv
// Channel | Dir | Handshake            | Payload
// in      | in  | in_valid / in_stall  | in_data  (in_item_t: one body byte)
// out     | out | out_valid / out_stall| out_data (out_item_t: fixup or error)
// cfg     | in  | cfg_valid / cfg_ready| cfg_data (ledata_segment, 15 bits)
//
// One byte per cycle while in_stall is low. A result is registered at the edge
// that takes the byte completing it, into the output register or its skid entry.
// Thread updates and skipped bytes give no result.
// Reset clears the parser, the eight threads and ledata_segment.
// in_stall rises only when the output register and its skid entry are both
// full; it is a registered signal, never a path from out_stall.
// cfg_ready is always high; write only while the block is quiet.
module omf_fixup_subrecord_parser import omfp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [14:0] cfg_data
);

	logic        ledata_q;
	logic [14:0] ledata_seg_q;
	logic        step;
	logic        res_valid;
	out_item_t   res;
	logic        out_valid_q;
	out_item_t   out_q;
	logic        skid_valid_q;
	out_item_t   skid_q;
	logic        pop;

	assign cfg_ready = 1'b1;
	assign in_stall  = skid_valid_q;
	assign step      = in_valid && !skid_valid_q;
	assign pop       = out_valid_q && !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// ledata_q marks that the register has seen a write since reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ledata_seg_q <= '0;
			ledata_q     <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			ledata_seg_q <= cfg_data;
			ledata_q     <= 1'b1;
		end
	end

	omfp_parser u_parser (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.item           (in_data),
		.ledata_segment (ledata_seg_q),
		.res_valid      (res_valid),
		.res            (res)
	);

	// output register with one skid entry behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
			out_q        <= '0;
			skid_q       <= '0;
		end else if (skid_valid_q) begin
			if (pop) begin
				out_q        <= skid_q;
				skid_valid_q <= 1'b0;
			end
		end else if (!out_valid_q || pop) begin
			out_valid_q <= res_valid;
			if (res_valid) begin
				out_q <= res;
			end
		end else if (res_valid) begin
			skid_q       <= res;
			skid_valid_q <= 1'b1;
		end
	end

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held with empty output register");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall && res_valid |=> skid_valid_q)
		else $error("transfer lost while output stalled");

	a_skid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && out_stall |=> skid_valid_q && $stable(skid_q))
		else $error("skid entry changed while stalled");

	a_cfg_seen: assert property (@(posedge clk) disable iff (!arst_n)
		!ledata_q |-> ledata_seg_q == '0)
		else $error("ledata segment changed without a write");

endmodule

### hdl/omfp_parser.sv
module omfp_parser import omfp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  in_item_t    item,
	input  logic [14:0] ledata_segment,
	output logic        res_valid,
	output out_item_t   res
);

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_FIX_LO,
		PH_FIX_DATA,
		PH_FRAME_IDX,
		PH_FRAME_IDX2,
		PH_TARGET_IDX,
		PH_TARGET_IDX2,
		PH_DISP,
		PH_THREAD_IDX,
		PH_THREAD_IDX2
	} phase_t;

	phase_t      phase_q, phase_d;
	logic        skip_q, skip_d;
	logic [7:0]  first_q, first_d;
	logic [7:0]  fd_q, fd_d;
	logic [7:0]  off_q, off_d;
	logic [14:0] fidx_q, fidx_d;
	logic [14:0] tidx_q, tidx_d;
	logic        wide_q, wide_d;
	logic [31:0] disp_q, disp_d;
	logic [2:0]  left_q, left_d;

	logic [2:0]  fthr_meth_q [4];
	logic [14:0] fthr_idx_q  [4];
	logic [1:0]  tthr_meth_q [4];
	logic [14:0] tthr_idx_q  [4];

	logic        thr_commit;
	logic [14:0] thr_idx;
	logic        after_fr, after_tg, do_fin, do_err;
	logic [7:0]  b;
	logic [2:0]  thr_m;
	logic [2:0]  cm_frame;
	logic [1:0]  cm_target;

	assign b = item.data_byte;

	always_comb begin
		phase_d    = phase_q;
		skip_d     = skip_q;
		first_d    = first_q;
		fd_d       = fd_q;
		off_d      = off_q;
		fidx_d     = fidx_q;
		tidx_d     = tidx_q;
		wide_d     = wide_q;
		disp_d     = disp_q;
		left_d     = left_q;
		thr_commit = 1'b0;
		thr_idx    = '0;
		after_fr   = 1'b0;
		after_tg   = 1'b0;
		do_fin     = 1'b0;
		do_err     = 1'b0;
		thr_m      = '0;
		if (skip_q) begin
			if (item.last_in_record) begin
				skip_d = 1'b0;
			end
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
					first_d = b;
					if (b[7]) begin
						phase_d = PH_FIX_LO;
					end else if (b[5]) begin
						// invalid thread byte
						do_err = 1'b1;
						skip_d = !item.last_in_record;
					end else begin
						thr_m = b[6] ? b[4:2] : {1'b0, b[3:2]};
						if (thr_m <= METHOD_LAST_INDEXED) begin
							phase_d = PH_THREAD_IDX;
						end else begin
							thr_commit = 1'b1;
						end
					end
				end
				PH_FIX_LO: begin
					off_d   = b;
					fidx_d  = '0;
					tidx_d  = '0;
					wide_d  = 1'b0;
					phase_d = PH_FIX_DATA;
				end
				PH_FIX_DATA: begin
					fd_d   = b;
					wide_d = item.wide_displacement;
					if (!b[7] && b[6:4] <= METHOD_LAST_INDEXED) begin
						phase_d = PH_FRAME_IDX;
					end else begin
						after_fr = 1'b1;
					end
				end
				PH_FRAME_IDX: begin
					if (b[7]) begin
						fidx_d  = {b[6:0], 8'h00};
						phase_d = PH_FRAME_IDX2;
					end else begin
						fidx_d   = {7'h00, b};
						after_fr = 1'b1;
					end
				end
				PH_FRAME_IDX2: begin
					fidx_d   = fidx_q | {7'h00, b};
					after_fr = 1'b1;
				end
				PH_TARGET_IDX: begin
					if (b[7]) begin
						tidx_d  = {b[6:0], 8'h00};
						phase_d = PH_TARGET_IDX2;
					end else begin
						tidx_d   = {7'h00, b};
						after_tg = 1'b1;
					end
				end
				PH_TARGET_IDX2: begin
					tidx_d   = tidx_q | {7'h00, b};
					after_tg = 1'b1;
				end
				PH_DISP: begin
					disp_d = {b, disp_q[31:8]};
					if (left_q != '0) begin
						left_d = left_q - 3'd1;
					end
					if (left_d == '0) begin
						do_fin = 1'b1;
					end
				end
				PH_THREAD_IDX: begin
					if (b[7]) begin
						fidx_d  = {b[6:0], 8'h00};
						phase_d = PH_THREAD_IDX2;
					end else begin
						thr_commit = 1'b1;
						thr_idx    = {7'h00, b};
					end
				end
				PH_THREAD_IDX2: begin
					thr_commit = 1'b1;
					thr_idx    = fidx_q | {7'h00, b};
				end
				default: phase_d = PH_IDLE;
			endcase

			if (after_fr) begin
				if (!fd_d[3]) begin
					phase_d = PH_TARGET_IDX;
				end else begin
					after_tg = 1'b1;
				end
			end
			if (after_tg) begin
				if (!fd_d[2]) begin
					phase_d = PH_DISP;
					left_d  = wide_d ? DISP_BYTES_DWORD : DISP_BYTES_WORD;
					disp_d  = '0;
				end else begin
					do_fin = 1'b1;
				end
			end
			if (do_fin || thr_commit) begin
				phase_d = PH_IDLE;
			end
			// record ends inside a subrecord
			if (item.last_in_record && phase_d != PH_IDLE) begin
				do_err  = 1'b1;
				phase_d = PH_IDLE;
			end
		end
	end

	// result assembly from the post-byte view of the subrecord
	always_comb begin
		logic [2:0]  fm;
		logic [14:0] fi;
		logic [1:0]  tm;
		logic [14:0] ti;
		logic [31:0] dv;
		if (fd_d[7]) begin
			fm = fthr_meth_q[fd_d[5:4]];
			fi = fthr_idx_q[fd_d[5:4]];
		end else begin
			fm = fd_d[6:4];
			fi = (fd_d[6:4] <= METHOD_LAST_INDEXED) ? fidx_d : '0;
		end
		if (fd_d[3]) begin
			tm = tthr_meth_q[fd_d[1:0]];
			ti = tthr_idx_q[fd_d[1:0]];
		end else begin
			tm = fd_d[1:0];
			ti = tidx_d;
		end
		if (fd_d[2]) begin
			dv = '0;
		end else if (wide_d) begin
			dv = disp_d;
		end else begin
			dv = {16'h0000, disp_d[31:16]};
		end
		if (fm == METHOD_FRAME_LEDATA) begin
			fm = METHOD_FRAME_SEGDEF;
			fi = ledata_segment;
		end
		if (do_err) begin
			res             = '0;
			res.result_kind = KIND_ERROR;
		end else begin
			res.result_kind   = KIND_FIXUP;
			res.seg_rel       = first_d[6];
			res.location_type = first_d[5:2];
			res.data_offset   = {first_d[1:0], off_d};
			res.frame_meth    = fm;
			res.frame_idx     = fi;
			res.tgt_meth      = tm;
			res.tgt_idx       = ti;
			res.tgt_disp      = dv;
		end
	end

	assign res_valid = step && (do_fin || do_err);
	assign cm_frame  = first_d[4:2];
	assign cm_target = first_d[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			skip_q  <= 1'b0;
			first_q <= '0;
			fd_q    <= '0;
			off_q   <= '0;
			fidx_q  <= '0;
			tidx_q  <= '0;
			wide_q  <= 1'b0;
			disp_q  <= '0;
			left_q  <= '0;
			for (int i = 0; i < 4; i++) begin
				fthr_meth_q[i] <= '0;
				fthr_idx_q[i]  <= '0;
				tthr_meth_q[i] <= '0;
				tthr_idx_q[i]  <= '0;
			end
		end else if (step) begin
			phase_q <= phase_d;
			skip_q  <= skip_d;
			first_q <= first_d;
			fd_q    <= fd_d;
			off_q   <= off_d;
			fidx_q  <= fidx_d;
			tidx_q  <= tidx_d;
			wide_q  <= wide_d;
			disp_q  <= disp_d;
			left_q  <= left_d;
			if (thr_commit) begin
				if (first_d[6]) begin
					fthr_meth_q[first_d[1:0]] <= cm_frame;
					fthr_idx_q[first_d[1:0]]  <=
						(cm_frame <= METHOD_LAST_INDEXED) ? thr_idx : '0;
				end else begin
					tthr_meth_q[first_d[1:0]] <= cm_target;
					tthr_idx_q[first_d[1:0]]  <=
						({1'b0, cm_target} <= METHOD_LAST_INDEXED) ? thr_idx : '0;
				end
			end
		end
	end

	a_skip_silent: assert property (@(posedge clk) disable iff (!arst_n)
		step && skip_q |-> !res_valid)
		else $error("result produced while skipping record");

	a_err_sets_skip: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.result_kind == KIND_ERROR && !item.last_in_record
		|=> skip_q && phase_q == PH_IDLE)
		else $error("mid-record error did not start skip");

	a_last_ends_sub: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.last_in_record |=> phase_q == PH_IDLE && !skip_q)
		else $error("parser state survived end of record");

	a_disp_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DISP |-> left_q != '0 && left_q <= DISP_BYTES_DWORD)
		else $error("displacement byte count out of range");

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

// FIXUPP body parser check: bytes go in one transfer at a time, a local parser
// model predicts each fixup or error result, and every output transfer is
// compared field by field with the oldest prediction.
module testbench;
	import omfp_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 8;
	localparam int IDLE_PERCENT  = 19;
	localparam int PHASE_BYTES   = 225;

	// lead byte of a subrecord
	localparam logic [7:0] LEAD_FIXUP      = 8'h80;
	localparam logic [7:0] LEAD_FRAME      = 8'h40;
	localparam logic [7:0] LEAD_BAD_THREAD = 8'hA0;
	// FIX DATA byte
	localparam logic [7:0] FD_FRAME_THREAD  = 8'h80;
	localparam logic [7:0] FD_TARGET_THREAD = 8'h08;
	localparam logic [7:0] FD_NO_DISP       = 8'h04;
	// first byte of an index: two-byte form
	localparam logic [7:0] INDEX_WIDE = 8'h80;

	localparam logic [14:0] LEDATA_TOP = 15'h7FFF;

	typedef enum logic [3:0] {
		PH_IDLE, PH_LOC_LO, PH_FIX_DATA, PH_FRAME_IX, PH_FRAME_IX2,
		PH_TARGET_IX, PH_TARGET_IX2, PH_DISP, PH_THREAD_IX, PH_THREAD_IX2
	} parse_phase_t;

	typedef struct packed {
		in_item_t  stim;
		logic      pinned;
		out_item_t want;
	} dir_row_t;

	localparam out_item_t NO_RESULT  = '0;
	localparam out_item_t ERROR_ITEM = {KIND_ERROR, {($bits(out_item_t) - 1){1'b0}}};
	// thread fixup: frame thread 0 holds method four, target thread 3 is (2, 7F)
	localparam out_item_t FIX_THREADS = {KIND_FIXUP, 1'b1, 4'hF, 10'h3FF,
		METHOD_FRAME_SEGDEF, LEDATA_TOP, 2'd2, 15'h007F, 32'h0000_0000};
	// explicit fixup: two-byte indexes, dword displacement all ones
	localparam out_item_t FIX_EXPLICIT = {KIND_FIXUP, 1'b0, 4'h0, 10'h000,
		METHOD_FRAME_SEGDEF, 15'h0000, 2'd0, 15'h7FFF, 32'hFFFF_FFFF};

	// stim = {data_byte, last_in_record, wide_displacement}
	localparam dir_row_t DIRECTED [25] = '{
		'{{8'h50, 1'b0, 1'b0}, 1'b0, NO_RESULT},    // frame thread 0, method four
		'{{8'h41, 1'b0, 1'b0}, 1'b0, NO_RESULT},    // frame thread 1, method 0
		'{{8'hFF, 1'b0, 1'b0}, 1'b0, NO_RESULT},
		'{{8'hFF, 1'b0, 1'b0}, 1'b0, NO_RESULT},    //   index 7FFF
		'{{8'h0B, 1'b0, 1'b0}, 1'b0, NO_RESULT},    // target thread 3, method 2
		'{{8'h7F, 1'b0, 1'b0}, 1'b0, NO_RESULT},
		'{{8'hFF, 1'b0, 1'b0}, 1'b0, NO_RESULT},    // fixup, top offset and location
		'{{8'hFF, 1'b0, 1'b0}, 1'b0, NO_RESULT},
		'{{8'h8F, 1'b0, 1'b0}, 1'b1, FIX_THREADS},  // both via threads, no disp
		'{{8'h80, 1'b0, 1'b0}, 1'b0, NO_RESULT},    // fixup, zero offset
		'{{8'h00, 1'b0, 1'b0}, 1'b0, NO_RESULT},
		'{{8'h00, 1'b0, 1'b1}, 1'b0, NO_RESULT},    // explicit, dword disp
		'{{8'h80, 1'b0, 1'b0}, 1'b0, NO_RESULT},
		'{{8'h00, 1'b0, 1'b0}, 1'b0, NO_RESULT},
		'{{8'hFF, 1'b0, 1'b0}, 1'b0, NO_RESULT},
		'{{8'hFF, 1'b0, 1'b0}, 1'b0, NO_RESULT},
		'{{8'hFF, 1'b0, 1'b0}, 1'b0, NO_RESULT},
		'{{8'hFF, 1'b0, 1'b0}, 1'b0, NO_RESULT},
		'{{8'hFF, 1'b0, 1'b0}, 1'b0, NO_RESULT},
		'{{8'hFF, 1'b1, 1'b0}, 1'b1, FIX_EXPLICIT},
		'{{8'h20, 1'b0, 1'b0}, 1'b1, ERROR_ITEM},   // bad thread byte mid record
		'{{8'h12, 1'b1, 1'b0}, 1'b0, NO_RESULT},    //   skipped up to the last byte
		'{{8'h84, 1'b1, 1'b0}, 1'b1, ERROR_ITEM},   // record ends inside a fixup
		'{{8'h3F, 1'b1, 1'b0}, 1'b1, ERROR_ITEM},   // bad thread byte as last byte
		'{{8'h4C, 1'b1, 1'b1}, 1'b0, NO_RESULT}     // frame thread, method without index
	};

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	in_item_t    in_data   = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [14:0] cfg_data  = '0;

	omf_fixup_subrecord_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// parser model state
	parse_phase_t parse_ph    = PH_IDLE;
	logic [7:0]   lead        = '0;
	logic [7:0]   fix_dat     = '0;
	logic [7:0]   off_lo      = '0;
	logic [14:0]  frm_ix      = '0;
	logic [14:0]  tgt_ix      = '0;
	logic         wide_disp   = 1'b0;
	logic [31:0]  disp_acc    = '0;
	logic [2:0]   disp_left   = '0;
	logic         skipping    = 1'b0;
	logic [14:0]  ledata_seg  = '0;
	logic [2:0]   fthr_method [4] = '{default: '0};
	logic [14:0]  fthr_index  [4] = '{default: '0};
	logic [1:0]   tthr_method [4] = '{default: '0};
	logic [14:0]  tthr_index  [4] = '{default: '0};

	out_item_t predicted_fixups [$];
	in_item_t  rec_bytes [$];

	bit calm = 1'b0;
	int cycles, failures, bytes_parsed, records_sent, cfg_writes, fixups_seen, errors_seen;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(posedge clk)
		out_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);

	// ---- parser model ----

	function automatic out_item_t fixup_done();
		out_item_t r;
		logic [1:0] ft, tt;
		r = '0;
		ft = fix_dat[5:4];
		tt = fix_dat[1:0];
		if ((fix_dat & FD_FRAME_THREAD) != 0) begin
			r.frame_meth = fthr_method[ft];
			r.frame_idx  = fthr_index[ft];
		end else begin
			r.frame_meth = fix_dat[6:4];
			r.frame_idx  = (fix_dat[6:4] <= METHOD_LAST_INDEXED) ? frm_ix : '0;
		end
		if ((fix_dat & FD_TARGET_THREAD) != 0) begin
			r.tgt_meth = tthr_method[tt];
			r.tgt_idx  = tthr_index[tt];
		end else begin
			r.tgt_meth = fix_dat[1:0];
			r.tgt_idx  = tgt_ix;
		end
		if ((fix_dat & FD_NO_DISP) != 0)
			r.tgt_disp = '0;
		else if (wide_disp)
			r.tgt_disp = disp_acc;
		else
			r.tgt_disp = disp_acc >> 16;
		// frame from the previous data record's segment
		if (r.frame_meth == METHOD_FRAME_LEDATA) begin
			r.frame_meth = METHOD_FRAME_SEGDEF;
			r.frame_idx  = ledata_seg;
		end
		r.result_kind   = KIND_FIXUP;
		r.seg_rel       = lead[6];
		r.location_type = lead[5:2];
		r.data_offset   = {lead[1:0], off_lo};
		parse_ph = PH_IDLE;
		return r;
	endfunction

	function automatic bit target_known(output out_item_t res);
		res = '0;
		if ((fix_dat & FD_NO_DISP) == 0) begin
			parse_ph  = PH_DISP;
			disp_left = wide_disp ? DISP_BYTES_DWORD : DISP_BYTES_WORD;
			disp_acc  = '0;
			return 1'b0;
		end
		res = fixup_done();
		return 1'b1;
	endfunction

	function automatic bit frame_known(output out_item_t res);
		res = '0;
		if ((fix_dat & FD_TARGET_THREAD) == 0) begin
			parse_ph = PH_TARGET_IX;
			return 1'b0;
		end
		return target_known(res);
	endfunction

	function automatic void commit_thread(input logic [14:0] ix);
		logic [1:0] t;
		logic [2:0] m;
		t = lead[1:0];
		if ((lead & LEAD_FRAME) != 0) begin
			m = lead[4:2];
			fthr_method[t] = m;
			fthr_index[t]  = (m <= METHOD_LAST_INDEXED) ? ix : '0;
		end else begin
			m = {1'b0, lead[3:2]};
			tthr_method[t] = m[1:0];
			tthr_index[t]  = (m <= METHOD_LAST_INDEXED) ? ix : '0;
		end
		parse_ph = PH_IDLE;
	endfunction

	// advances the model by one body byte; returns 1 when a result falls out
	function automatic bit parse_byte(input in_item_t it, output out_item_t res);
		logic [7:0] b;
		logic [2:0] m;
		bit got;
		b = it.data_byte;
		got = 1'b0;
		res = '0;
		if (skipping) begin
			if (it.last_in_record)
				skipping = 1'b0;
			return 1'b0;
		end
		case (parse_ph)
			PH_IDLE: begin
				lead = b;
				if ((b & LEAD_FIXUP) != 0) begin
					parse_ph = PH_LOC_LO;
				end else if ((b & LEAD_BAD_THREAD) != 0) begin
					res = ERROR_ITEM;
					skipping = !it.last_in_record;
					return 1'b1;
				end else begin
					m = ((b & LEAD_FRAME) != 0) ? b[4:2] : {1'b0, b[3:2]};
					if (m <= METHOD_LAST_INDEXED)
						parse_ph = PH_THREAD_IX;
					else
						commit_thread('0);
				end
			end
			PH_LOC_LO: begin
				off_lo    = b;
				frm_ix    = '0;
				tgt_ix    = '0;
				wide_disp = 1'b0;
				parse_ph  = PH_FIX_DATA;
			end
			PH_FIX_DATA: begin
				fix_dat = b;
				if (it.wide_displacement)
					wide_disp = 1'b1;
				if ((b & FD_FRAME_THREAD) == 0 && b[6:4] <= METHOD_LAST_INDEXED)
					parse_ph = PH_FRAME_IX;
				else
					got = frame_known(res);
			end
			PH_FRAME_IX: begin
				if ((b & INDEX_WIDE) != 0) begin
					frm_ix   = {b[6:0], 8'h00};
					parse_ph = PH_FRAME_IX2;
				end else begin
					frm_ix = {8'h00, b[6:0]};
					got = frame_known(res);
				end
			end
			PH_FRAME_IX2: begin
				frm_ix = frm_ix | {7'h00, b};
				got = frame_known(res);
			end
			PH_TARGET_IX: begin
				if ((b & INDEX_WIDE) != 0) begin
					tgt_ix   = {b[6:0], 8'h00};
					parse_ph = PH_TARGET_IX2;
				end else begin
					tgt_ix = {8'h00, b[6:0]};
					got = target_known(res);
				end
			end
			PH_TARGET_IX2: begin
				tgt_ix = tgt_ix | {7'h00, b};
				got = target_known(res);
			end
			PH_DISP: begin
				disp_acc = {b, disp_acc[31:8]};
				if (disp_left != 0)
					disp_left = disp_left - 1'b1;
				if (disp_left == 0) begin
					res = fixup_done();
					got = 1'b1;
				end
			end
			PH_THREAD_IX: begin
				// thread index shares the frame index holding field
				if ((b & INDEX_WIDE) != 0) begin
					frm_ix   = {b[6:0], 8'h00};
					parse_ph = PH_THREAD_IX2;
				end else begin
					commit_thread({8'h00, b[6:0]});
				end
			end
			PH_THREAD_IX2: commit_thread(frm_ix | {7'h00, b});
			default: parse_ph = PH_IDLE;
		endcase
		// record ended inside a subrecord: drop it
		if (it.last_in_record && parse_ph != PH_IDLE) begin
			res = ERROR_ITEM;
			parse_ph = PH_IDLE;
			got = 1'b1;
		end
		return got;
	endfunction

	// ---- driving ----

	task automatic send_byte(input in_item_t it, input bit pinned, input out_item_t want);
		out_item_t predicted;
		bit got, was_skipping;
		while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (in_stall);
		was_skipping = skipping;
		got = parse_byte(it, predicted);
		if (pinned)
			predicted_fixups.push_back(want);
		else if (got)
			predicted_fixups.push_back(predicted);
		if (!was_skipping)
			bytes_parsed++;
	endtask

	task automatic write_ledata(input logic [14:0] seg);
		cfg_valid <= 1'b1;
		cfg_data  <= seg;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		ledata_seg = seg;
		cfg_writes++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (predicted_fixups.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// ---- random record building ----

	function automatic void add_byte(input logic [7:0] b, input logic wide);
		in_item_t it;
		it.data_byte = b;
		it.last_in_record = 1'b0;
		it.wide_displacement = wide;
		rec_bytes.push_back(it);
	endfunction

	function automatic void add_index();
		if ($urandom_range(1)) begin
			add_byte(8'($urandom_range(0, 127)), 1'($urandom_range(1)));
		end else begin
			add_byte(INDEX_WIDE | 8'($urandom_range(0, 127)), 1'($urandom_range(1)));
			add_byte(8'($urandom_range(0, 255)), 1'($urandom_range(1)));
		end
	endfunction

	function automatic void add_subrecord();
		logic [7:0] b, fd;
		logic [2:0] m;
		logic wide;
		if ($urandom_range(99) < 30) begin
			if ($urandom_range(1)) begin
				m = 3'($urandom_range(7));
				b = {1'b0, 1'b1, 1'b0, m, 2'($urandom_range(3))};
			end else begin
				m = {1'b0, 2'($urandom_range(3))};
				b = {3'b000, 1'($urandom_range(1)), m[1:0], 2'($urandom_range(3))};
			end
			add_byte(b, 1'($urandom_range(1)));
			if (m <= METHOD_LAST_INDEXED)
				add_index();
		end else begin
			add_byte(LEAD_FIXUP | 8'($urandom_range(0, 127)), 1'($urandom_range(1)));
			add_byte(8'($urandom_range(0, 255)), 1'($urandom_range(1)));
			fd = 8'($urandom_range(0, 255));
			wide = 1'($urandom_range(1));
			add_byte(fd, wide);
			if ((fd & FD_FRAME_THREAD) == 0 && fd[6:4] <= METHOD_LAST_INDEXED)
				add_index();
			if ((fd & FD_TARGET_THREAD) == 0)
				add_index();
			if ((fd & FD_NO_DISP) == 0)
				repeat (wide ? DISP_BYTES_DWORD : DISP_BYTES_WORD)
					add_byte(8'($urandom_range(0, 255)), 1'($urandom_range(1)));
		end
	endfunction

	// mostly well-formed records, some cut short, some pure noise
	task automatic send_record();
		in_item_t tail;
		int pick, keep;
		rec_bytes.delete();
		pick = $urandom_range(99);
		if (pick < 90) begin
			repeat ($urandom_range(1, 5))
				add_subrecord();
			if (pick >= 80 && rec_bytes.size() > 1) begin
				keep = $urandom_range(1, rec_bytes.size() - 1);
				while (rec_bytes.size() > keep)
					void'(rec_bytes.pop_back());
			end
		end else begin
			repeat ($urandom_range(1, 8))
				add_byte(8'($urandom_range(0, 255)), 1'($urandom_range(1)));
		end
		tail = rec_bytes.pop_back();
		tail.last_in_record = 1'b1;
		rec_bytes.push_back(tail);
		foreach (rec_bytes[i])
			send_byte(rec_bytes[i], 1'b0, NO_RESULT);
		records_sent++;
	endtask

	// ---- checking ----

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			failures++;
		end
	endtask

	always @(posedge clk) begin : check_results
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (predicted_fixups.size() == 0) begin
				$error("result transfer with nothing expected: kind %0d", out_data.result_kind);
				failures++;
			end else begin
				want = predicted_fixups.pop_front();
				if (out_data.result_kind == KIND_ERROR)
					errors_seen++;
				else
					fixups_seen++;
				check_field("result_kind", 32'(want.result_kind), 32'(out_data.result_kind));
				check_field("seg_rel", 32'(want.seg_rel), 32'(out_data.seg_rel));
				check_field("location_type", 32'(want.location_type),
					32'(out_data.location_type));
				check_field("data_offset", 32'(want.data_offset), 32'(out_data.data_offset));
				check_field("frame_meth", 32'(want.frame_meth), 32'(out_data.frame_meth));
				check_field("frame_idx", 32'(want.frame_idx), 32'(out_data.frame_idx));
				check_field("tgt_meth", 32'(want.tgt_meth), 32'(out_data.tgt_meth));
				check_field("tgt_idx", 32'(want.tgt_idx), 32'(out_data.tgt_idx));
				check_field("tgt_disp", want.tgt_disp, out_data.tgt_disp);
			end
		end
	end

	// ---- sequence ----

	initial begin
		int goal;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// top segment first, so the thread fixup row shows the substitution
		write_ledata(LEDATA_TOP);
		for (int i = 0; i < $size(DIRECTED); i++)
			send_byte(DIRECTED[i].stim, DIRECTED[i].pinned, DIRECTED[i].want);
		drain();

		goal = bytes_parsed;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: write_ledata('0);
				1: write_ledata(15'($urandom_range(0, 32767)));
				2: write_ledata(15'($urandom_range(0, 32767)));
				default: write_ledata(LEDATA_TOP);
			endcase
			// one phase with no idling on either side
			calm = (ph == 2);
			goal += PHASE_BYTES;
			while (bytes_parsed < goal)
				send_record();
			drain();
		end
		calm = 1'b0;

		$display("Fed %0d parsed bytes in %0d random records across %0d segment settings.",
			bytes_parsed, records_sent, cfg_writes);
		$display("Compared %0d fixups and %0d error results, %0d mismatches.",
			fixups_seen, errors_seen, failures);
		if (failures == 0 && predicted_fixups.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
